// ===== rtl/core/spag_pkg.sv =====
// Shared types, board constants and bit-shuffle helpers for the sliding
// piece attack generator. No dependencies.
`default_nettype none

package spag_pkg;

  localparam int unsigned BoardW  = 64;
  localparam int unsigned SquareW = 6;
  localparam int unsigned CoordW  = 3;
  localparam int unsigned RowW    = 8;

  typedef logic [BoardW-1:0]  board_t;
  typedef logic [SquareW-1:0] square_t;
  typedef logic [RowW-1:0]    row_t;

  typedef enum logic {
    OP_ORTHO = 1'b0,
    OP_DIAG  = 1'b1
  } opcode_t;

  localparam board_t FileAMask = 64'h0101_0101_0101_0101;
  localparam board_t DiagMain  = 64'h8040_2010_0804_0201;
  localparam board_t DiagAnti  = 64'h0102_0408_1020_4080;

  // Swap rank order: byte i goes to byte 7-i.
  function automatic board_t byte_reverse(input board_t x);
    board_t r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = x[8*(7-i) +: 8];
    end
    return r;
  endfunction

  function automatic row_t bit_reverse(input row_t x);
    row_t r;
    r = '0;
    for (int i = 0; i < RowW; i++) begin
      r[i] = x[RowW-1-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/spag_line.sv =====
// Attack set along a line holding one square per rank (file or diagonal),
// using the o^(o-2r) subtraction with byte reversal. Uses spag_pkg.
`default_nettype none

module spag_line
  import spag_pkg::*;
(
  input  board_t occupancy,
  input  board_t slider,
  input  board_t line_mask,
  output board_t attacks
);

  board_t o;
  board_t fwd;
  board_t rev;

  always_comb begin
    o   = occupancy & line_mask;
    fwd = o - (slider << 1);
    rev = byte_reverse(o) - (byte_reverse(slider) << 1);
    attacks = (fwd ^ byte_reverse(rev)) & line_mask;
  end

endmodule

`default_nettype wire

// ===== rtl/core/spag_rank.sv =====
// Attack set along the slider's rank: 8-bit subtraction trick with bit
// reversal, then placed back on the board. Uses spag_pkg.
`default_nettype none

module spag_rank
  import spag_pkg::*;
(
  input  board_t  occupancy,
  input  square_t square,
  output board_t  attacks
);

  logic [CoordW-1:0] rank;
  logic [CoordW-1:0] file;
  row_t row;
  row_t s;
  row_t fwd;
  row_t rev;
  row_t hits;

  always_comb begin
    rank = square[SquareW-1:CoordW];
    file = square[CoordW-1:0];
    row  = occupancy[{rank, 3'b000} +: RowW];
    s    = row_t'(1) << file;
    fwd  = row - (s << 1);
    rev  = bit_reverse(row) - (bit_reverse(s) << 1);
    hits = fwd ^ bit_reverse(rev);
    attacks = board_t'(hits) << {rank, 3'b000};
  end

endmodule

`default_nettype wire

// ===== rtl/core/spag_core.sv =====
// Single-pass attack logic: line masks from the square, two line units and
// the rank unit, merged by slider kind. Uses spag_pkg, spag_line, spag_rank.
`default_nettype none

module spag_core
  import spag_pkg::*;
(
  input  opcode_t opcode,
  input  square_t square,
  input  board_t  occupancy,
  output board_t  attacks
);

  logic [CoordW-1:0] rank;
  logic [CoordW-1:0] file;
  logic [CoordW:0]   k;
  board_t slider;
  board_t occ;
  board_t dmain;
  board_t danti;
  board_t mask0;
  board_t line0;
  board_t line1;
  board_t rank_hits;

  always_comb begin
    rank   = square[SquareW-1:CoordW];
    file   = square[CoordW-1:0];
    k      = {1'b0, rank} + {1'b0, file};
    slider = board_t'(1) << square;
    occ    = occupancy | slider;
    if (rank >= file) begin
      dmain = DiagMain << {rank - file, 3'b000};
    end else begin
      dmain = DiagMain >> {file - rank, 3'b000};
    end
    if (k >= 4'd7) begin
      danti = DiagAnti << {k[CoordW-1:0] - 3'd7, 3'b000};
    end else begin
      danti = DiagAnti >> {3'd7 - k[CoordW-1:0], 3'b000};
    end
    mask0 = (opcode == OP_DIAG) ? dmain : (FileAMask << file);
  end

  spag_line u_line0 (
    .occupancy (occ),
    .slider    (slider),
    .line_mask (mask0),
    .attacks   (line0)
  );

  spag_line u_line1 (
    .occupancy (occ),
    .slider    (slider),
    .line_mask (danti),
    .attacks   (line1)
  );

  spag_rank u_rank (
    .occupancy (occ),
    .square    (square),
    .attacks   (rank_hits)
  );

  assign attacks = (opcode == OP_DIAG) ? (line0 | line1) : (line0 | rank_hits);

endmodule

`default_nettype wire

// ===== rtl/core/sliding_piece_attack_generator_unit.sv =====
// Top level of the sliding piece attack generator: request register,
// single-pass attack logic, result register. Uses spag_pkg, spag_core.
//
//   channel   handshake               payload
//   request   req_valid / req_ready   opcode, square, occupancy
//   response  rsp_valid / rsp_ready   attacks
//
// A request passes through the request register, then through spag_core
// into the result register; the two register stages form a pipeline.
// One request per cycle is sustained while the response is not stalled.
// A stalled response holds the result register; the request register keeps
// accepting until it too is full.
// Synchronous reset clears only the two valid flags.
`default_nettype none

module sliding_piece_attack_generator_unit
  import spag_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output      logic         req_ready,
  input  wire logic         opcode,
  input  wire logic [5:0]   square,
  input  wire logic [63:0]  occupancy,
  output      logic         rsp_valid,
  input  wire logic         rsp_ready,
  output      logic [63:0]  attacks
);

  logic    s1_valid;
  opcode_t s1_opcode;
  square_t s1_square;
  board_t  s1_occupancy;
  board_t  attacks_next;
  logic    out_load;
  logic    s1_load;

  assign out_load  = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || out_load;
  assign s1_load   = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_opcode    <= opcode_t'(opcode);
      s1_square    <= square;
      s1_occupancy <= occupancy;
    end
  end

  spag_core u_core (
    .opcode    (s1_opcode),
    .square    (s1_square),
    .occupancy (s1_occupancy),
    .attacks   (attacks_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      attacks <= attacks_next;
    end
  end

  // Backpressure only when both stages are full and the response stalls.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (s1_valid && rsp_valid && !rsp_ready))
    else $error("request stalled without a full pipeline");

  // A held request moves on whenever the result register is free.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !rsp_valid) |=> rsp_valid)
    else $error("request stage did not advance");

  // The slider's own square never shows up in the attack set.
  a_own_square: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_load) |=> (attacks[$past(s1_square)] == 1'b0))
    else $error("own square attacked");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!s1_valid && !rsp_valid))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ===== sim/spag_attack_checker.sv =====
`timescale 1ns / 100ps
// Response checker for the sliding piece attack generator: predicts the attack
// set of each accepted request and compares it with the returned response.
// Depends on spag_pkg for board, square and opcode types and board constants.

module spag_attack_checker
  import spag_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  wire logic        req_ready,
  input  wire logic        opcode,
  input  wire logic [5:0]  square,
  input  wire logic [63:0] occupancy,
  input  wire logic        rsp_valid,
  input  wire logic        rsp_ready,
  input  wire logic [63:0] attacks,
  output int               fail_count,
  output int               pending,
  output int               checked,
  output int               ortho_seen,
  output int               diag_seen
);

  typedef struct {
    opcode_t kind;
    square_t sq;
    board_t  occ;
    board_t  want;
  } attack_query_t;

  attack_query_t awaiting_attacks[$];
  attack_query_t head;
  int errors = 0;
  int n_checked = 0;
  int n_ortho = 0;
  int n_diag = 0;

  function automatic board_t flip_ranks(board_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24],
            x[39:32], x[47:40], x[55:48], x[63:56]};
  endfunction

  // o ^ (o - 2r) both ways along a line with one square per rank
  function automatic board_t line_reach(board_t occ, board_t s, board_t line);
    board_t o;
    board_t up;
    board_t down;
    o    = occ & line;
    up   = o - (s << 1);
    down = flip_ranks(o) - (flip_ranks(s) << 1);
    return (up ^ flip_ranks(down)) & line;
  endfunction

  function automatic board_t rank_reach(board_t occ, int rank, int file);
    logic [7:0] row;
    logic [7:0] hits;
    row  = occ[rank*8 +: 8];
    hits = '0;
    for (int f = file + 1; f < 8; f++) begin
      hits[f] = 1'b1;
      if (row[f]) break;
    end
    for (int f = file - 1; f >= 0; f--) begin
      hits[f] = 1'b1;
      if (row[f]) break;
    end
    return board_t'(hits) << (rank * 8);
  endfunction

  function automatic board_t attack_set(opcode_t kind, square_t sq, board_t occ_in);
    int     rank;
    int     file;
    board_t s;
    board_t occ;
    board_t dmain;
    board_t danti;
    rank = int'(sq[5:3]);
    file = int'(sq[2:0]);
    s    = board_t'(1) << sq;
    occ  = occ_in | s;
    if (kind == OP_ORTHO) begin
      return line_reach(occ, s, FileAMask << file) | rank_reach(occ, rank, file);
    end
    if (rank >= file) dmain = DiagMain << (8 * (rank - file));
    else dmain = DiagMain >> (8 * (file - rank));
    if (rank + file >= 7) danti = DiagAnti << (8 * (rank + file - 7));
    else danti = DiagAnti >> (8 * (7 - rank - file));
    return line_reach(occ, s, dmain) | line_reach(occ, s, danti);
  endfunction

  task automatic report(string what, board_t got, board_t want);
    $display("[%0t] mismatch: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (awaiting_attacks.size() == 0) begin
          report("response with no request outstanding", attacks, '0);
        end else begin
          head = awaiting_attacks.pop_front();
          n_checked++;
          if (attacks !== head.want) begin
            report($sformatf("attacks for %s sq %0d occ %h", head.kind.name(), head.sq,
                             head.occ), attacks, head.want);
          end
        end
      end
      if (req_valid && req_ready) begin
        head.kind = opcode_t'(opcode);
        head.sq   = square;
        head.occ  = occupancy;
        head.want = attack_set(head.kind, square, occupancy);
        awaiting_attacks.push_back(head);
        if (head.kind == OP_ORTHO) n_ortho++;
        else n_diag++;
      end
    end
    fail_count <= errors;
    pending    <= awaiting_attacks.size();
    checked    <= n_checked;
    ortho_seen <= n_ortho;
    diag_seen  <= n_diag;
  end

endmodule

// ===== sim/sliding_piece_attack_generator_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for sliding_piece_attack_generator_unit: drives directed and
// random attack queries with bursty requests and a stalling receiver.
// Depends on spag_pkg, the RTL and spag_attack_checker.

module sliding_piece_attack_generator_unit_tb;
  import spag_pkg::*;

  localparam int RandomRequests = 1350;
  localparam int CycleLimit     = 200000;
  localparam int HoldStart      = 100;
  localparam int HoldCycles     = 60;
  localparam int DrainCycles    = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic        opcode = 1'b0;
  logic [5:0]  square = '0;
  logic [63:0] occupancy = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [63:0] attacks;

  int fail_count;
  int pending;
  int checked;
  int ortho_seen;
  int diag_seen;
  int sent = 0;
  int cycles = 0;
  int burst_left = 0;

  sliding_piece_attack_generator_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .opcode    (opcode),
    .square    (square),
    .occupancy (occupancy),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .attacks   (attacks)
  );

  spag_attack_checker CHK (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .opcode     (opcode),
    .square     (square),
    .occupancy  (occupancy),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .attacks    (attacks),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .ortho_seen (ortho_seen),
    .diag_seen  (diag_seen)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic board_t random_board();
    board_t a;
    board_t b;
    board_t c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return a;
      1: return a & b;
      2: return a & b & c;
      3: return a | b;
      4: return ~(a & b & c);
      default: return (board_t'(1) << $urandom_range(0, 63)) | (a & b & c & {$urandom, $urandom});
    endcase
  endfunction

  // Valid stays high across a burst and drops between bursts.
  task automatic send(opcode_t op, square_t sq, board_t occ);
    req_valid <= 1'b1;
    opcode    <= op;
    square    <= sq;
    occupancy <= occ;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_valid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(8, 30) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Receiver: one long hold-off, otherwise shifting stall patterns.
  initial begin
    int   mode;
    int   left;
    logic held;
    mode = 0;
    left = 0;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held && sent >= HoldStart) begin
        rsp_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        held = 1'b1;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= ($urandom_range(0, 3) != 0);
        2: rsp_ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ready <= (left % 3 != 0);
      endcase
    end
  end

  initial begin
    opcode_t op;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < 2; k++) begin
      op = opcode_t'(k);
      send(op, 6'd0, '0);
      send(op, 6'd7, '0);
      send(op, 6'd56, '0);
      send(op, 6'd63, '0);
      send(op, 6'd27, '1);
      send(op, 6'd36, board_t'(1) << 36);
      send(op, 6'd35, '0);
      send(op, 6'd63, ~(board_t'(1) << 63));
      send(op, 6'd28, random_board());
    end

    for (int n = 0; n < RandomRequests; n++) begin
      send(opcode_t'($urandom_range(0, 1)), square_t'($urandom_range(0, 63)), random_board());
    end
    req_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d requests, checked %0d responses", sent, checked);
    $display("orthogonal %0d, diagonal %0d, with a %0d-cycle receiver hold-off",
             ortho_seen, diag_seen, HoldCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/spag_pkg.sv
rtl/core/spag_line.sv
rtl/core/spag_rank.sv
rtl/core/spag_core.sv
rtl/core/sliding_piece_attack_generator_unit.sv
sim/spag_attack_checker.sv
sim/sliding_piece_attack_generator_unit_tb.sv
